>>> hdl/mrsp_pkg.sv
package mrsp_pkg;

    // Frame limits and CRC constants
    localparam int MAX_FRAME_BYTES_DEFAULT = 32;
    localparam int MIN_REPLY_BYTES        = 9;
    localparam logic [7:0]  EXCEPTION_BIT = 8'h80;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    // Configuration reset values
    localparam logic [7:0] SLAVE_ADDRESS_RESET  = 8'd2;
    localparam logic [6:0] FUNCTION_CODE_RESET  = 7'd3;
    localparam logic [6:0] REGISTER_COUNT_RESET = 7'd2;

    // Byte positions of the captured reply fields
    localparam int POS_ADDRESS  = 0;
    localparam int POS_FUNCTION = 1;
    localparam int POS_COUNT    = 2;
    localparam int POS_HUM_HI   = 3;
    localparam int POS_HUM_LO   = 4;
    localparam int POS_TEMP_HI  = 5;
    localparam int POS_TEMP_LO  = 6;

    typedef enum logic [1:0] {
        CFG_SLAVE_ADDRESS  = 2'd0,
        CFG_FUNCTION_CODE  = 2'd1,
        CFG_REGISTER_COUNT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_BAD_ADDR  = 3'd2,
        VERDICT_EXCEPTION = 3'd3,
        VERDICT_CRC_ERROR = 3'd4,
        VERDICT_BAD_COUNT = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        STATUS_NO_RESPONSE = 2'd0,
        STATUS_VALID       = 2'd1,
        STATUS_ERROR       = 2'd2
    } sensor_status_t;

    // Frame contents as they stand once the current byte is taken
    typedef struct packed {
        logic        enough_bytes;
        logic [7:0]  address;
        logic [7:0]  function_code;
        logic [7:0]  byte_count;
        logic [15:0] crc;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } frame_view_t;

    // Modbus CRC-16, one byte, reflected polynomial
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> hdl/mrsp_frame.sv
module mrsp_frame
    import mrsp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic        byte_valid,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output frame_view_t view
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       addr_reg, addr_next;
    logic [7:0]       func_reg, func_next;
    logic [7:0]       count_reg, count_next;
    logic [15:0]      hum_reg, hum_next;
    logic [15:0]      temp_reg, temp_next;
    logic             take;

    // Take the byte while the frame has room
    always_comb begin
        take       = byte_valid && (pos_reg < POS_W'(MAX_FRAME_BYTES));
        pos_next   = pos_reg;
        crc_next   = crc_reg;
        addr_next  = addr_reg;
        func_next  = func_reg;
        count_next = count_reg;
        hum_next   = hum_reg;
        temp_next  = temp_reg;
        if (take) begin
            pos_next = pos_reg + POS_W'(1);
            crc_next = crc_feed(crc_reg, rx_byte);
            if (pos_reg == POS_W'(POS_ADDRESS))  addr_next  = rx_byte;
            if (pos_reg == POS_W'(POS_FUNCTION)) func_next  = rx_byte;
            if (pos_reg == POS_W'(POS_COUNT))    count_next = rx_byte;
            if (pos_reg == POS_W'(POS_HUM_HI))   hum_next   = {rx_byte, hum_reg[7:0]};
            if (pos_reg == POS_W'(POS_HUM_LO))   hum_next   = {hum_reg[15:8], rx_byte};
            if (pos_reg == POS_W'(POS_TEMP_HI))  temp_next  = {rx_byte, temp_reg[7:0]};
            if (pos_reg == POS_W'(POS_TEMP_LO))  temp_next  = {temp_reg[15:8], rx_byte};
        end
    end

    assign view.enough_bytes  = (pos_next >= POS_W'(MIN_REPLY_BYTES));
    assign view.address       = addr_next;
    assign view.function_code = func_next;
    assign view.byte_count    = count_next;
    assign view.crc           = crc_next;
    assign view.humidity      = hum_next;
    assign view.temperature   = temp_next;

    // Advance on each item, clear once the frame is judged
    always_ff @(posedge aclk) begin
        if (!aresetn || (step && frame_end)) begin
            pos_reg   <= '0;
            crc_reg   <= CRC_INIT;
            addr_reg  <= '0;
            func_reg  <= '0;
            count_reg <= '0;
            hum_reg   <= '0;
            temp_reg  <= '0;
        end else if (step) begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            count_reg <= count_next;
            hum_reg   <= hum_next;
            temp_reg  <= temp_next;
        end
    end

`ifndef SYNTHESIS
    // A judged frame leaves a clean start for the next one
    a_clear_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        step && frame_end |=> pos_reg == '0 && crc_reg == CRC_INIT)
        else $error("frame state not cleared after frame end");

    // The position never runs past the frame limit
    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_FRAME_BYTES))
        else $error("byte position beyond frame limit");

    // Bytes beyond the limit leave the CRC untouched
    a_overflow_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !frame_end && pos_reg == POS_W'(MAX_FRAME_BYTES) |=> $stable(crc_reg))
        else $error("CRC changed on an ignored byte");
`endif

endmodule

>>> hdl/modbus_rtu_sensor_response_parser.sv
// Modbus RTU read-holding-registers reply checker for a humidity and
// temperature sensor.
// Input stream: one received byte per request. s_tdata carries the byte,
// s_tuser says whether a byte is present (0 is a bare timeout mark) and
// s_tlast ends the frame. Every frame end produces one result on the
// master side with the verdict, status, last good reading and counters.
// Configuration: cfg_we writes cfg_wdata into register cfg_index
// (0 slave address, 1 function code, 2 register count); write only while idle.
// A request is registered in the input register, then processed from there;
// its result is loaded into the result register, which drives m_tvalid.
// Throughput: one request per cycle while no frame end waits, set by the
// combinational CRC and field capture between the input and result registers.
// When the receiver stalls, the result register holds; the input register
// still takes bytes that give no result, and a frame end waits in it,
// holding s_tready low, until the result register frees.
// Reset (aresetn low, synchronous) clears the frame state, the held
// reading, both counters and the configuration to its defaults.
module modbus_rtu_sensor_response_parser
    import mrsp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tuser,   // [0] byte_present
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] verdict, [4:3] sensor_status, [20:5] humidity_raw,
    // [36:21] temperature_raw, [68:37] good_reads, [100:69] failed_reads
    output logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata
);

    logic [7:0]  slave_addr_reg;
    logic [6:0]  func_code_reg;
    logic [6:0]  reg_count_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_present_reg;
    logic        in_last_reg;
    logic        advance;
    logic        load_out;

    frame_view_t view;

    verdict_t       verdict_next;
    sensor_status_t status_next;
    logic [15:0]    held_hum_reg, held_hum_next;
    logic [15:0]    held_temp_reg, held_temp_next;
    logic [31:0]    good_cnt_reg, good_cnt_next;
    logic [31:0]    fail_cnt_reg, fail_cnt_next;

    logic           out_valid_reg;
    verdict_t       out_verdict_reg;
    sensor_status_t out_status_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_addr_reg <= SLAVE_ADDRESS_RESET;
            func_code_reg  <= FUNCTION_CODE_RESET;
            reg_count_reg  <= REGISTER_COUNT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SLAVE_ADDRESS:  slave_addr_reg <= cfg_wdata;
                CFG_FUNCTION_CODE:  func_code_reg  <= cfg_wdata[6:0];
                CFG_REGISTER_COUNT: reg_count_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // Handshake: a frame end may only move on when the result register frees
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign load_out = advance && in_last_reg;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    mrsp_frame #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .byte_valid(in_present_reg),
        .rx_byte   (in_byte_reg),
        .frame_end (in_last_reg),
        .view      (view)
    );

    // Judge the frame: length, address and function, CRC, byte count
    always_comb begin
        priority if (!view.enough_bytes) begin
            verdict_next = VERDICT_SHORT;
            status_next  = STATUS_NO_RESPONSE;
        end else if (view.address != slave_addr_reg ||
                     view.function_code != {1'b0, func_code_reg}) begin
            verdict_next = ((view.function_code & EXCEPTION_BIT) != 8'h00) ?
                           VERDICT_EXCEPTION : VERDICT_BAD_ADDR;
            status_next  = STATUS_ERROR;
        end else if (view.crc != 16'h0000) begin
            verdict_next = VERDICT_CRC_ERROR;
            status_next  = STATUS_ERROR;
        end else if (view.byte_count != {reg_count_reg, 1'b0}) begin
            verdict_next = VERDICT_BAD_COUNT;
            status_next  = STATUS_ERROR;
        end else begin
            verdict_next = VERDICT_OK;
            status_next  = STATUS_VALID;
        end
    end

    // Update the held reading and the counters
    always_comb begin
        held_hum_next  = held_hum_reg;
        held_temp_next = held_temp_reg;
        good_cnt_next  = good_cnt_reg;
        fail_cnt_next  = fail_cnt_reg;
        if (verdict_next == VERDICT_OK) begin
            held_hum_next  = view.humidity;
            held_temp_next = view.temperature;
            good_cnt_next  = good_cnt_reg + 32'd1;
        end else begin
            fail_cnt_next  = fail_cnt_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_hum_reg  <= '0;
            held_temp_reg <= '0;
            good_cnt_reg  <= '0;
            fail_cnt_reg  <= '0;
        end else if (load_out) begin
            held_hum_reg  <= held_hum_next;
            held_temp_reg <= held_temp_next;
            good_cnt_reg  <= good_cnt_next;
            fail_cnt_reg  <= fail_cnt_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_verdict_reg <= verdict_next;
            out_status_reg  <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, fail_cnt_reg, good_cnt_reg, held_temp_reg, held_hum_reg,
                       out_status_reg, out_verdict_reg};

`ifndef SYNTHESIS
    // Every result bumps exactly one of the two counters
    a_one_count_per_result: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> (32'(good_cnt_reg + fail_cnt_reg)) ==
                     32'($past(good_cnt_reg) + $past(fail_cnt_reg) + 32'd1))
        else $error("counters did not advance by one per result");

    // Verdict and status agree on a good reading
    a_verdict_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> ((out_verdict_reg == VERDICT_OK) == (out_status_reg == STATUS_VALID)))
        else $error("verdict and status disagree");

    // The held reading only moves on a good frame
    a_held_on_good: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(held_hum_reg) || !$stable(held_temp_reg) |->
            $past(load_out) && $past(verdict_next == VERDICT_OK))
        else $error("held reading changed without a good frame");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |-> !load_out)
        else $error("result overwritten while stalled");
`endif

endmodule

>>> tb/mrsp_reply_checker.sv
`timescale 1ns / 1ps

package mrsp_tb_pkg;

    import mrsp_pkg::*;

    // Advance the Modbus CRC-16 by one byte, least significant bit first
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] octet);
        logic [15:0] r;
        r = acc ^ {8'h00, octet};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

module mrsp_reply_checker
    import mrsp_pkg::*;
    import mrsp_tb_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_wdata,
    output int           results_due,
    output int           mismatch_count
);

    typedef struct packed {
        verdict_t       verdict;
        sensor_status_t status;
        logic [15:0]    humidity;
        logic [15:0]    temperature;
        logic [31:0]    good;
        logic [31:0]    failed;
    } reply_report_t;

    reply_report_t reply_reports_q[$];

    // Configuration copy
    logic [7:0]  want_address;
    logic [6:0]  want_function;
    logic [6:0]  want_registers;

    // Frame being received
    logic [5:0]  frame_pos;
    logic [15:0] frame_crc;
    logic [7:0]  rx_address;
    logic [7:0]  rx_function;
    logic [7:0]  rx_byte_count;
    logic [15:0] rx_humidity;
    logic [15:0] rx_temperature;

    // Reading and counters kept across frames
    logic [15:0]    kept_humidity;
    logic [15:0]    kept_temperature;
    logic [31:0]    good_total;
    logic [31:0]    fail_total;
    sensor_status_t link_status;

    task automatic compare_field(input string name, input logic signed [32:0] want,
                                 input logic signed [32:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Match one result against the oldest expected report
    task automatic check_report(input logic [103:0] word);
        reply_report_t want;
        if (reply_reports_q.size() == 0) begin
            $error("result with no reply pending: %h", word);
            mismatch_count++;
            return;
        end
        want = reply_reports_q.pop_front();
        compare_field("verdict", want.verdict, word[2:0]);
        compare_field("sensor_status", want.status, word[4:3]);
        compare_field("humidity_raw", want.humidity, word[20:5]);
        compare_field("temperature_raw", $signed(want.temperature), $signed(word[36:21]));
        compare_field("good_reads", want.good, word[68:37]);
        compare_field("failed_reads", want.failed, word[100:69]);
    endtask

    // Take one request into the frame and judge the frame at its end
    task automatic judge_reply_byte(input logic [7:0] rx, input logic present,
                                    input logic ends);
        reply_report_t rep;
        verdict_t      v;
        if (present && frame_pos < MAX_FRAME_BYTES_DEFAULT) begin
            frame_crc = crc16_step(frame_crc, rx);
            case (int'(frame_pos))
                POS_ADDRESS:  rx_address = rx;
                POS_FUNCTION: rx_function = rx;
                POS_COUNT:    rx_byte_count = rx;
                POS_HUM_HI:   rx_humidity[15:8] = rx;
                POS_HUM_LO:   rx_humidity[7:0] = rx;
                POS_TEMP_HI:  rx_temperature[15:8] = rx;
                POS_TEMP_LO:  rx_temperature[7:0] = rx;
                default: ;
            endcase
            frame_pos = frame_pos + 6'd1;
        end
        if (!ends) begin
            return;
        end

        // Checks in priority order: length, header, CRC, byte count
        if (frame_pos < MIN_REPLY_BYTES) begin
            v = VERDICT_SHORT;
            link_status = STATUS_NO_RESPONSE;
        end else if (rx_address != want_address || rx_function != {1'b0, want_function}) begin
            v = ((rx_function & EXCEPTION_BIT) != 8'h00) ? VERDICT_EXCEPTION : VERDICT_BAD_ADDR;
            link_status = STATUS_ERROR;
        end else if (frame_crc != 16'h0000) begin
            v = VERDICT_CRC_ERROR;
            link_status = STATUS_ERROR;
        end else if (rx_byte_count != {want_registers, 1'b0}) begin
            v = VERDICT_BAD_COUNT;
            link_status = STATUS_ERROR;
        end else begin
            v = VERDICT_OK;
            link_status = STATUS_VALID;
        end

        if (v == VERDICT_OK) begin
            kept_humidity = rx_humidity;
            kept_temperature = rx_temperature;
            good_total = good_total + 32'd1;
        end else begin
            fail_total = fail_total + 32'd1;
        end

        rep.verdict = v;
        rep.status = link_status;
        rep.humidity = kept_humidity;
        rep.temperature = kept_temperature;
        rep.good = good_total;
        rep.failed = fail_total;
        reply_reports_q.push_back(rep);

        // Drop the frame state for the next reply
        frame_pos = '0;
        frame_crc = CRC_INIT;
        rx_address = '0;
        rx_function = '0;
        rx_byte_count = '0;
        rx_humidity = '0;
        rx_temperature = '0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            want_address = SLAVE_ADDRESS_RESET;
            want_function = FUNCTION_CODE_RESET;
            want_registers = REGISTER_COUNT_RESET;
            frame_pos = '0;
            frame_crc = CRC_INIT;
            rx_address = '0;
            rx_function = '0;
            rx_byte_count = '0;
            rx_humidity = '0;
            rx_temperature = '0;
            kept_humidity = '0;
            kept_temperature = '0;
            good_total = '0;
            fail_total = '0;
            link_status = STATUS_NO_RESPONSE;
            mismatch_count = 0;
            reply_reports_q.delete();
        end else begin
            // Results first, so a new frame end never masks a stray result
            if (m_tvalid === 1'b1 && m_tready) begin
                check_report(m_tdata);
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SLAVE_ADDRESS:  want_address = cfg_wdata;
                    CFG_FUNCTION_CODE:  want_function = cfg_wdata[6:0];
                    CFG_REGISTER_COUNT: want_registers = cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready === 1'b1) begin
                judge_reply_byte(s_tdata, s_tuser, s_tlast);
            end
        end
        results_due <= reply_reports_q.size();
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import mrsp_pkg::*;
    import mrsp_tb_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_REQUESTS = 275;

    typedef enum {
        SHAPE_GOOD,
        SHAPE_CRC_FLIP,
        SHAPE_WRONG_ADDR,
        SHAPE_WRONG_FUNC,
        SHAPE_EXCEPTION,
        SHAPE_WRONG_COUNT,
        SHAPE_SHORT,
        SHAPE_OVERLONG,
        SHAPE_NOISE
    } reply_shape_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [7:0]   cfg_wdata = '0;

    int results_due;
    int mismatch_count;
    int cycle_count = 0;
    int requests_sent = 0;
    bit gaps_on = 1'b1;

    logic [7:0] reply_bytes[$];
    logic [7:0] cur_address = SLAVE_ADDRESS_RESET;
    logic [6:0] cur_function = FUNCTION_CODE_RESET;
    logic [6:0] cur_registers = REGISTER_COUNT_RESET;

    always #1 aclk = ~aclk;

    modbus_rtu_sensor_response_parser DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    mrsp_reply_checker u_reply_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    // Receiver stalls at random while gaps are on
    always @(posedge aclk) begin
        if (!gaps_on) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 12);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request and hold it until accepted; valid stays high afterwards
    task automatic send_item(input logic [7:0] data, input logic present, input logic mark_end);
        while (gaps_on && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= present;
        s_tlast <= mark_end;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // Stop sending and wait until every reply report has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] addr, input logic [6:0] func,
                                input logic [6:0] regs);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SLAVE_ADDRESS;
        cfg_wdata <= addr;
        @(posedge aclk);
        cfg_index <= CFG_FUNCTION_CODE;
        cfg_wdata <= {1'b0, func};
        @(posedge aclk);
        cfg_index <= CFG_REGISTER_COUNT;
        cfg_wdata <= {1'b0, regs};
        @(posedge aclk);
        cfg_we <= 1'b0;
        cur_address = addr;
        cur_function = func;
        cur_registers = regs;
    endtask

    // Append the CRC, low byte first
    task automatic seal_crc();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (reply_bytes[i]) begin
            c = crc16_step(c, reply_bytes[i]);
        end
        reply_bytes.push_back(c[7:0]);
        reply_bytes.push_back(c[15:8]);
    endtask

    // Send the reply bytes; the frame ends on its last byte or on a bare timeout mark
    task automatic send_reply(input int marker_pct);
        bit on_marker;
        on_marker = (reply_bytes.size() == 0) || ($urandom_range(99) < marker_pct);
        foreach (reply_bytes[i]) begin
            if ($urandom_range(99) < 4) begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(reply_bytes[i], 1'b1, !on_marker && (i == reply_bytes.size() - 1));
            if (i < MAX_FRAME_BYTES_DEFAULT) begin
                requests_sent++;
            end
        end
        if (on_marker) begin
            send_item(8'($urandom), 1'b0, 1'b1);
            requests_sent++;
        end
    endtask

    // Build a reply for the current settings, then damage it as the shape says
    task automatic build_reply(input reply_shape_t shape);
        int data_len;
        int pick;
        reply_bytes.delete();
        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(40)) reply_bytes.push_back(8'($urandom));
            return;
        end
        data_len = ($urandom_range(9) == 0) ? $urandom_range(4, 27) : $urandom_range(4, 8);
        if (shape == SHAPE_OVERLONG) begin
            data_len = 27;
        end
        reply_bytes.push_back(cur_address);
        reply_bytes.push_back({1'b0, cur_function});
        reply_bytes.push_back({cur_registers, 1'b0});
        repeat (data_len) reply_bytes.push_back(8'($urandom));
        case (shape)
            SHAPE_WRONG_ADDR: reply_bytes[0] = reply_bytes[0] ^ 8'($urandom_range(1, 255));
            SHAPE_WRONG_FUNC: reply_bytes[1] = reply_bytes[1] ^ 8'($urandom_range(1, 127));
            SHAPE_WRONG_COUNT: reply_bytes[2] = reply_bytes[2] ^ 8'($urandom_range(1, 255));
            SHAPE_EXCEPTION: begin
                reply_bytes[1] = reply_bytes[1] | EXCEPTION_BIT;
                // a true exception reply is five bytes long
                if ($urandom_range(1) == 0) begin
                    while (reply_bytes.size() > 3) reply_bytes.delete(reply_bytes.size() - 1);
                end
            end
            default: ;
        endcase
        seal_crc();
        case (shape)
            SHAPE_CRC_FLIP: begin
                pick = $urandom_range(reply_bytes.size() - 1);
                reply_bytes[pick] = reply_bytes[pick] ^ 8'(1 << $urandom_range(7));
            end
            SHAPE_SHORT: begin
                pick = $urandom_range(8);
                while (reply_bytes.size() > pick) reply_bytes.delete(reply_bytes.size() - 1);
            end
            SHAPE_OVERLONG: begin
                repeat ($urandom_range(1, 8)) reply_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase
    endtask

    initial begin
        reply_shape_t shape;
        int pick;
        int phase_start;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: full-scale good reply ending on its last byte
        reply_bytes = '{8'h02, 8'h03, 8'h04, 8'hFF, 8'hFF, 8'h80, 8'h00};
        seal_crc();
        send_reply(0);
        // No reply at all: a bare timeout mark
        reply_bytes.delete();
        send_reply(100);
        // Exception reply of full length, ended by a timeout mark
        reply_bytes = '{8'h02, 8'h83, 8'h04, 8'h00, 8'h00, 8'h7F, 8'hFF};
        seal_crc();
        send_reply(100);
        // Short reply ending on its last byte
        reply_bytes = '{8'h02, 8'h03, 8'h04};
        send_reply(0);

        // Random phases under several settings
        for (int p = 0; p < 6; p++) begin
            drain_results();
            case (p)
                0: program_regs(8'h00, 7'h00, 7'h00);
                1: program_regs(8'hFF, 7'h7F, 7'h7F);
                2: program_regs(8'($urandom), 7'($urandom), 7'($urandom));
                3: program_regs(SLAVE_ADDRESS_RESET, FUNCTION_CODE_RESET, REGISTER_COUNT_RESET);
                4: program_regs(8'($urandom), 7'($urandom), 7'($urandom_range(13)));
                default: program_regs(8'($urandom), 7'($urandom), 7'($urandom));
            endcase
            // one phase runs with no idling on either side
            gaps_on = (p != 1);
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS) begin
                pick = $urandom_range(99);
                if (pick < 50)      shape = SHAPE_GOOD;
                else if (pick < 58) shape = SHAPE_CRC_FLIP;
                else if (pick < 64) shape = SHAPE_WRONG_ADDR;
                else if (pick < 70) shape = SHAPE_WRONG_FUNC;
                else if (pick < 76) shape = SHAPE_EXCEPTION;
                else if (pick < 83) shape = SHAPE_WRONG_COUNT;
                else if (pick < 90) shape = SHAPE_SHORT;
                else if (pick < 95) shape = SHAPE_OVERLONG;
                else                shape = SHAPE_NOISE;
                build_reply(shape);
                send_reply(30);
            end
        end
        drain_results();

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
